FILE: hw/rtl/ffca_pkg.sv
// ----------------------------------------------------------------------------
// First-fit chunk allocator package
// Field widths, status codes, beat payloads and the sequencer microprogram.
// ----------------------------------------------------------------------------
package ffca_pkg;

    localparam int INDEX_W             = 11;
    localparam int REQ_BYTES_W         = 15;
    localparam int STATUS_W            = 2;
    localparam int POOL_UNITS_DEFAULT  = 2048;
    localparam int UNIT_BYTES_DEFAULT  = 16;

    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_FREE     = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_ZERO_SIZE = 2'd2
    } status_t;

    typedef struct packed {
        logic                   operation;
        logic [REQ_BYTES_W-1:0] request_bytes;
        logic [INDEX_W-1:0]     release_index;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  granted_index;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_A_SIZE,
        S_A_INIT,
        S_A_CHECK,
        S_A_NEXT,
        S_A_TAKE,
        S_A_SPLIT,
        S_A_OK,
        S_A_NOSPACE,
        S_A_ZERO,
        S_F_CHK,
        S_F_REL,
        S_F_LOOK,
        S_F_MERGE
    } step_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_IS_FREE,
        C_ZERO_UNITS,
        C_FIT,
        C_STOP,
        C_SPLIT_EQ,
        C_BAD_RELEASE,
        C_BAD_LINK,
        C_CLEAR_DONE
    } cond_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_ZERO,
        RD_LINK,
        RD_HDR
    } rd_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_TAKE,
        WR_SPLIT,
        WR_RELEASE,
        WR_MERGE
    } wr_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_LINK,
        CUR_HDR
    } cur_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC
    } cnt_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_OK,
        EM_NO_SPACE,
        EM_ZERO,
        EM_FREE
    } emit_t;

    typedef struct packed {
        logic  take;
        rd_t   rd;
        wr_t   wr;
        cur_t  cur;
        cnt_t  cnt;
        emit_t emit;
        cond_t cond;
        step_t t_true;
        step_t t_false;
    } ucode_t;

    typedef struct packed {
        logic accept;
        logic is_free;
        logic zero_units;
        logic fit;
        logic stop;
        logic split_eq;
        logic bad_release;
        logic bad_link;
        logic clear_done;
    } cond_flags_t;

    function automatic ucode_t ucode_rom(step_t step);
        ucode_t w;
        w.take    = 1'b0;
        w.rd      = RD_NONE;
        w.wr      = WR_NONE;
        w.cur     = CUR_HOLD;
        w.cnt     = CNT_HOLD;
        w.emit    = EM_NONE;
        w.cond    = C_ALWAYS;
        w.t_true  = S_IDLE;
        w.t_false = S_IDLE;
        unique case (step)
            S_CLEAR:
            begin
                w.wr = WR_CLEAR; w.cnt = CNT_INC;
                w.cond = C_CLEAR_DONE; w.t_true = S_IDLE; w.t_false = S_CLEAR;
            end
            S_IDLE:
            begin
                w.take = 1'b1;
                w.cond = C_ACCEPT; w.t_true = S_DISPATCH; w.t_false = S_IDLE;
            end
            S_DISPATCH:
            begin
                w.cond = C_IS_FREE; w.t_true = S_F_CHK; w.t_false = S_A_SIZE;
            end
            S_A_SIZE:
            begin
                w.cond = C_ZERO_UNITS; w.t_true = S_A_ZERO; w.t_false = S_A_INIT;
            end
            S_A_INIT:
            begin
                w.rd = RD_ZERO; w.cur = CUR_ZERO; w.cnt = CNT_CLR;
                w.t_true = S_A_CHECK;
            end
            S_A_CHECK:
            begin
                w.cond = C_FIT; w.t_true = S_A_TAKE; w.t_false = S_A_NEXT;
            end
            S_A_NEXT:
            begin
                w.rd = RD_LINK; w.cur = CUR_LINK; w.cnt = CNT_INC;
                w.cond = C_STOP; w.t_true = S_A_NOSPACE; w.t_false = S_A_CHECK;
            end
            S_A_TAKE:
            begin
                w.wr = WR_TAKE;
                w.cond = C_SPLIT_EQ; w.t_true = S_A_OK; w.t_false = S_A_SPLIT;
            end
            S_A_SPLIT:
            begin
                w.wr = WR_SPLIT; w.t_true = S_A_OK;
            end
            S_A_OK:
            begin
                w.emit = EM_OK;
            end
            S_A_NOSPACE:
            begin
                w.emit = EM_NO_SPACE;
            end
            S_A_ZERO:
            begin
                w.emit = EM_ZERO;
            end
            S_F_CHK:
            begin
                w.rd = RD_HDR; w.cur = CUR_HDR;
                w.cond = C_BAD_RELEASE; w.t_true = S_F_MERGE; w.t_false = S_F_REL;
            end
            S_F_REL:
            begin
                w.wr = WR_RELEASE;
                w.cond = C_BAD_LINK; w.t_true = S_F_MERGE; w.t_false = S_F_LOOK;
            end
            S_F_LOOK:
            begin
                w.rd = RD_LINK; w.t_true = S_F_MERGE;
            end
            S_F_MERGE:
            begin
                w.wr = WR_MERGE; w.emit = EM_FREE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/ffca_stream_if.sv
// ----------------------------------------------------------------------------
// First-fit chunk allocator stream interface
// Valid/ready channel; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ffca_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/first_fit_chunk_allocator_unit.sv
// ----------------------------------------------------------------------------
// First-fit chunk allocator unit
// Header chain in a single-port memory, walked by a microcoded sequencer.
// ----------------------------------------------------------------------------
// A request beat carries an allocate (byte count) or a free (data unit
// index). Every request beat gives exactly one response beat with a status
// and, for a granted allocate, the first data unit of the chunk.
// One request is worked on at a time. An allocate walks the header chain
// from the first header and, when the chunk is split, writes one more
// header; each header visited costs one memory read and one check.
// After reset the block runs a clearing pass that writes the initial
// chain into the memory; request ready stays low then.
// The response sits in an output register. A new request is accepted while
// a response still waits; when the receiver stalls, the sequencer holds at
// its response step until the register is taken.
// ----------------------------------------------------------------------------
module first_fit_chunk_allocator_unit #(
    parameter int POOL_UNITS = ffca_pkg::POOL_UNITS_DEFAULT,
    parameter int UNIT_BYTES = ffca_pkg::UNIT_BYTES_DEFAULT
) (
    input logic           clk,
    input logic           rst_n,
    ffca_stream_if.sink   request,
    ffca_stream_if.source response
);
    import ffca_pkg::*;

    localparam int    IW        = $clog2(POOL_UNITS);
    localparam int    NW        = REQ_BYTES_W + 1;
    localparam int    RW        = NW + 1;
    localparam int    SH        = NW + $clog2(UNIT_BYTES);
    localparam longint RECIP    = ((64'd1 << SH) + UNIT_BYTES - 1) / UNIT_BYTES;
    localparam int    MAX_UNITS = ((2 ** REQ_BYTES_W) - 1 + UNIT_BYTES - 1) / UNIT_BYTES;
    localparam int    UW        = $clog2(MAX_UNITS + 1);
    localparam int    CW        = ((IW > UW) ? IW : UW) + 1;
    localparam int    XW        = IW + INDEX_W;
    localparam logic [IW-1:0] LAST = IW'(POOL_UNITS - 1);

    logic [IW:0] mem [POOL_UNITS];

    ucode_t      ctrl;
    cond_flags_t flags;
    logic        hold;
    logic        accept;

    logic               op_reg;
    logic [UW-1:0]      units_reg;
    logic [INDEX_W-1:0] rel_reg;
    logic [IW-1:0]      cur_reg;
    logic [IW-1:0]      cur_next;
    logic [IW-1:0]      cnt_reg;
    logic [IW:0]        rdata_reg;

    logic [NW-1:0]      numer;
    logic [NW+RW-1:0]   prod;
    logic               rd_occ;
    logic [IW-1:0]      rd_link;
    logic [IW-1:0]      hdr;
    logic [IW-1:0]      gap;
    logic [IW-1:0]      split;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [IW:0]        wr_data;

    logic               out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [INDEX_W-1:0] out_granted_reg;

    ffca_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .hold  (hold),
        .ctrl  (ctrl)
    );

    assign request.ready = ctrl.take;
    assign accept        = request.valid && ctrl.take;

    assign response.valid                 = out_valid_reg;
    assign response.payload.status        = out_status_reg;
    assign response.payload.granted_index = out_granted_reg;

    assign hold = (ctrl.emit != EM_NONE) && out_valid_reg && !response.ready;

    assign numer = NW'(request.payload.request_bytes) + NW'(UNIT_BYTES - 1);
    assign prod  = (NW+RW)'(numer) * (NW+RW)'(RECIP);

    assign rd_occ  = rdata_reg[IW];
    assign rd_link = rdata_reg[IW-1:0];
    assign hdr     = IW'(rel_reg - INDEX_W'(1));
    assign gap     = rd_link - cur_reg - IW'(1);
    assign split   = IW'(CW'(cur_reg) + CW'(units_reg) + CW'(1));

    always_comb
    begin
        flags.accept      = accept;
        flags.is_free     = (op_reg == OP_FREE);
        flags.zero_units  = (units_reg == '0);
        flags.fit         = !rd_occ && (rd_link > cur_reg) && (CW'(gap) >= CW'(units_reg));
        flags.bad_link    = (rd_link == '0) || ((IW+1)'(rd_link) >= (IW+1)'(POOL_UNITS));
        flags.stop        = flags.bad_link || (cnt_reg == LAST);
        flags.split_eq    = (split == rd_link);
        flags.bad_release = (rel_reg == '0) || (XW'(rel_reg) >= XW'(POOL_UNITS));
        flags.clear_done  = (cnt_reg == LAST);
    end

    always_comb
    begin
        rd_en   = (ctrl.rd != RD_NONE);
        rd_addr = '0;
        unique case (ctrl.rd)
            RD_NONE: rd_addr = '0;
            RD_ZERO: rd_addr = '0;
            RD_LINK: rd_addr = rd_link;
            RD_HDR:  rd_addr = hdr;
            default: rd_addr = '0;
        endcase

        unique case (ctrl.cur)
            CUR_HOLD: cur_next = cur_reg;
            CUR_ZERO: cur_next = '0;
            CUR_LINK: cur_next = rd_link;
            CUR_HDR:  cur_next = hdr;
            default:  cur_next = cur_reg;
        endcase

        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = {1'b0, rd_link};
        unique case (ctrl.wr)
            WR_NONE:
            begin
                wr_en = 1'b0;
            end
            WR_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = (cnt_reg == '0) ? {1'b0, LAST} : {(cnt_reg == LAST), IW'(0)};
            end
            WR_TAKE:
            begin
                wr_en   = 1'b1;
                wr_data = {1'b1, split};
            end
            WR_SPLIT:
            begin
                wr_en   = 1'b1;
                wr_addr = split;
            end
            WR_RELEASE:
            begin
                wr_en = 1'b1;
            end
            WR_MERGE:
            begin
                wr_en = !rd_occ && !flags.bad_release;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= request.payload.operation;
            rel_reg   <= request.payload.release_index;
            units_reg <= UW'(prod >> SH);
        end
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            unique case (ctrl.cnt)
                CNT_HOLD: cnt_reg <= cnt_reg;
                CNT_CLR:  cnt_reg <= '0;
                CNT_INC:  cnt_reg <= cnt_reg + IW'(1);
                default:  cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((ctrl.emit != EM_NONE) && !hold)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((ctrl.emit != EM_NONE) && !hold)
        begin
            unique case (ctrl.emit)
                EM_OK:
                begin
                    out_status_reg  <= ST_OK;
                    out_granted_reg <= INDEX_W'(cur_reg + IW'(1));
                end
                EM_NO_SPACE:
                begin
                    out_status_reg  <= ST_NO_SPACE;
                    out_granted_reg <= '0;
                end
                EM_ZERO:
                begin
                    out_status_reg  <= ST_ZERO_SIZE;
                    out_granted_reg <= '0;
                end
                default:
                begin
                    out_status_reg  <= ST_OK;
                    out_granted_reg <= '0;
                end
            endcase
        end
    end

    a_load_free_slot : assert property (@(posedge clk) disable iff (!rst_n)
        ((ctrl.emit != EM_NONE) && !hold) |-> (!out_valid_reg || response.ready))
        else $error("response register overwritten before it was taken");

    a_take_in_chunk : assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.wr == WR_TAKE) |-> (rd_link > cur_reg) && (split <= rd_link) && !rd_occ)
        else $error("allocation does not fit inside the free chunk");

    a_write_in_pool : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((IW+1)'(wr_addr) < (IW+1)'(POOL_UNITS)))
        else $error("header write outside the pool");

    a_no_grant_on_fail : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_granted_reg == '0))
        else $error("failed allocate carries a granted index");

    a_no_accept_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cnt == CNT_INC) |-> !request.ready)
        else $error("request taken while walking or clearing");

endmodule

FILE: hw/rtl/ffca_seq.sv
// ----------------------------------------------------------------------------
// First-fit chunk allocator sequencer
// Step counter over the microprogram ROM with two-way conditional jumps.
// ----------------------------------------------------------------------------
module ffca_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ffca_pkg::cond_flags_t flags,
    input  logic                  hold,
    output ffca_pkg::ucode_t      ctrl
);
    import ffca_pkg::*;

    step_t upc_reg;
    step_t upc_next;
    logic  taken;

    assign ctrl = ucode_rom(upc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            C_ALWAYS:      taken = 1'b1;
            C_ACCEPT:      taken = flags.accept;
            C_IS_FREE:     taken = flags.is_free;
            C_ZERO_UNITS:  taken = flags.zero_units;
            C_FIT:         taken = flags.fit;
            C_STOP:        taken = flags.stop;
            C_SPLIT_EQ:    taken = flags.split_eq;
            C_BAD_RELEASE: taken = flags.bad_release;
            C_BAD_LINK:    taken = flags.bad_link;
            C_CLEAR_DONE:  taken = flags.clear_done;
            default:       taken = 1'b1;
        endcase
        if (hold)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = taken ? ctrl.t_true : ctrl.t_false;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule
